@@ sv/hpbc_pkg.sv @@
// Package for the homography point box classifier: payload structs, opcodes,
// controller states and datapath command/status types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hpbc_pkg;

    localparam int MAX_BOXES_DEF = 16;
    localparam logic [2:0] NO_CLASS = 3'd6;
    localparam int NUM_REGS = 8;
    localparam int Q_FRAC = 16;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_ADD     = 2'd1;
    localparam logic [1:0] OP_PROJECT = 2'd2;

    localparam logic [2:0] REG_H00 = 3'd0;
    localparam logic [2:0] REG_H01 = 3'd1;
    localparam logic [2:0] REG_H02 = 3'd2;
    localparam logic [2:0] REG_H10 = 3'd3;
    localparam logic [2:0] REG_H11 = 3'd4;
    localparam logic [2:0] REG_H12 = 3'd5;
    localparam logic [2:0] REG_H20 = 3'd6;
    localparam logic [2:0] REG_H21 = 3'd7;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [7:0]  box_class;
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic [14:0]        box_width;
        logic [14:0]        box_height;
        logic signed [15:0] bev_x;
        logic signed [15:0] bev_y;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] image_x;
        logic signed [15:0] image_y;
        logic [2:0]         class_id;
        logic               div_fault;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_SUM,
        ST_DIV_X, ST_DIV_Y, ST_SCAN, ST_OUT
    } state_t;

    typedef struct packed {
        logic load;       // capture input item
        logic clear;      // box_count to zero
        logic add;        // append box
        logic mul;        // run product step
        logic sum;        // form X, Y, W
        logic div_start;  // start divider on selected numerator
        logic div_sel_y;  // divider numerator select
        logic div_take;   // store divider result
        logic scan_start;
        logic scan_step;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic scan_done;
    } stat_t;

endpackage
`default_nettype wire

@@ sv/hpbc_ctrl.sv @@
// Controller state machine of the homography point box classifier.
// Depends on hpbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hpbc_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire [1:0]         in_op,
    input  hpbc_pkg::stat_t   stat,
    output hpbc_pkg::cmd_t    cmd,
    output logic              m_valid,
    input  wire               m_ready
);
    import hpbc_pkg::*;

    state_t state_reg, state_next;
    logic [1:0] mstep_reg, mstep_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mstep_reg <= '0;
        end else begin
            state_reg <= state_next;
            mstep_reg <= mstep_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mstep_next = mstep_reg;
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.clear = (in_op == OP_CLEAR);
                    cmd.add = (in_op == OP_ADD);
                    cmd.load = 1'b1;
                    if (in_op == OP_PROJECT) begin
                        state_next = ST_MUL_A;
                        mstep_next = '0;
                    end
                end
            end
            ST_MUL_A, ST_MUL_B, ST_MUL_C: begin
                // one product per step: six products across ST_MUL_A, ST_MUL_B and ST_MUL_C
                cmd.mul = 1'b1;
                mstep_next = mstep_reg + 2'd1;
                if (mstep_reg == 2'd1) begin
                    mstep_next = '0;
                    case (state_reg)
                        ST_MUL_A: state_next = ST_MUL_B;
                        ST_MUL_B: state_next = ST_MUL_C;
                        default:  state_next = ST_SUM;
                    endcase
                end
            end
            ST_SUM: begin
                cmd.sum = 1'b1;
                cmd.div_start = 1'b1;
                state_next = ST_DIV_X;
            end
            ST_DIV_X: begin
                if (stat.div_done) begin
                    cmd.div_take = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel_y = 1'b1;
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                cmd.div_sel_y = 1'b1;
                if (stat.div_done) begin
                    cmd.div_take = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_out_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_SCAN)
        else $error("result raised without scan");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input taken while result pending");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped");
`endif
endmodule
`default_nettype wire

@@ sv/hpbc_dpath.sv @@
// Datapath: coefficient registers, box store, product sums, serial divider
// and box scan. Depends on hpbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hpbc_dpath #(
    parameter int MAX_BOXES = hpbc_pkg::MAX_BOXES_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_valid,
    input  wire [2:0]           cfg_index,
    input  wire [31:0]          cfg_data,
    input  hpbc_pkg::in_item_t  in_item,
    input  hpbc_pkg::cmd_t      cmd,
    output hpbc_pkg::stat_t     stat,
    output hpbc_pkg::out_item_t out_item
);
    import hpbc_pkg::*;

    localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);

    logic signed [31:0] h_reg [NUM_REGS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                h_reg[i] <= (i == int'(REG_H00) || i == int'(REG_H11))
                    ? 32'sd65536 : 32'sd0;
            end
        end else if (cfg_valid) begin
            h_reg[cfg_index] <= cfg_data;
        end
    end

    // box store
    logic signed [15:0] st_left   [MAX_BOXES];
    logic signed [15:0] st_top    [MAX_BOXES];
    logic [14:0]        st_width  [MAX_BOXES];
    logic [14:0]        st_height [MAX_BOXES];
    logic [2:0]         st_class  [MAX_BOXES];
    logic [CW-1:0]      count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) count_reg <= '0;
        else if (cmd.clear) count_reg <= '0;
        else if (cmd.add && count_reg < CW'(MAX_BOXES)) count_reg <= count_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (cmd.add && count_reg < CW'(MAX_BOXES)) begin
            st_left[count_reg[IW-1:0]]   <= in_item.box_left;
            st_top[count_reg[IW-1:0]]    <= in_item.box_top;
            st_width[count_reg[IW-1:0]]  <= in_item.box_width;
            st_height[count_reg[IW-1:0]] <= in_item.box_height;
            st_class[count_reg[IW-1:0]]  <= (in_item.box_class >= 0 && in_item.box_class < 6)
                ? in_item.box_class[2:0] : NO_CLASS;
        end
    end

    // products: one 32x16 multiply per cycle
    logic signed [15:0] bx_reg, by_reg;
    logic [2:0] pidx_reg;
    logic signed [47:0] prod_reg [6];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            bx_reg <= in_item.bev_x;
            by_reg <= in_item.bev_y;
            pidx_reg <= '0;
        end else if (cmd.mul) begin
            pidx_reg <= pidx_reg + 3'd1;
        end
    end

    logic signed [31:0] mul_h;
    logic signed [15:0] mul_b;
    always_comb begin
        case (pidx_reg)
            3'd0: begin mul_h = h_reg[REG_H00]; mul_b = bx_reg; end
            3'd1: begin mul_h = h_reg[REG_H01]; mul_b = by_reg; end
            3'd2: begin mul_h = h_reg[REG_H10]; mul_b = bx_reg; end
            3'd3: begin mul_h = h_reg[REG_H11]; mul_b = by_reg; end
            3'd4: begin mul_h = h_reg[REG_H20]; mul_b = bx_reg; end
            default: begin mul_h = h_reg[REG_H21]; mul_b = by_reg; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) prod_reg[pidx_reg[2:0] > 3'd5 ? 3'd5 : pidx_reg] <= mul_h * mul_b;
    end

    logic signed [49:0] nx_reg, ny_reg, w_reg;
    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            nx_reg <= 50'(prod_reg[0]) + 50'(prod_reg[1]) + 50'(h_reg[REG_H02]);
            ny_reg <= 50'(prod_reg[2]) + 50'(prod_reg[3]) + 50'(h_reg[REG_H12]);
            w_reg  <= 50'(prod_reg[4]) + 50'(prod_reg[5]) + 50'sd65536;
        end
    end

    // restoring divider on magnitudes, one quotient bit per cycle
    localparam int DW = 50;
    logic [DW-1:0] rem_reg, quo_reg, dmag_reg;
    logic [5:0]    dcnt_reg;
    logic          dbusy_reg, dneg_reg, nzero_reg, nneg_reg, dsel_reg;
    logic signed [DW-1:0] num_sel;
    logic [DW-1:0] num_mag, w_mag, rem_sh;

    assign num_sel = cmd.div_sel_y ? ny_reg : nx_reg;
    // sum stage lands in the same cycle as the first start: read its inputs
    logic signed [49:0] nx_now, ny_now, w_now;
    assign nx_now = 50'(prod_reg[0]) + 50'(prod_reg[1]) + 50'(h_reg[REG_H02]);
    assign ny_now = 50'(prod_reg[2]) + 50'(prod_reg[3]) + 50'(h_reg[REG_H12]);
    assign w_now  = 50'(prod_reg[4]) + 50'(prod_reg[5]) + 50'sd65536;

    logic signed [DW-1:0] n_src, w_src;
    assign n_src = cmd.sum ? nx_now : num_sel;
    assign w_src = cmd.sum ? w_now : w_reg;
    assign num_mag = n_src[DW-1] ? DW'(-n_src) : DW'(n_src);
    assign w_mag = w_src[DW-1] ? DW'(-w_src) : DW'(w_src);
    assign rem_sh = {rem_reg[DW-2:0], quo_reg[DW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
        end else if (cmd.div_start) begin
            dbusy_reg <= 1'b1;
        end else if (dbusy_reg && dcnt_reg == 6'(DW - 1)) begin
            dbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_reg <= '0;
            quo_reg <= num_mag;
            dmag_reg <= w_mag;
            dcnt_reg <= '0;
            dneg_reg <= n_src[DW-1] ^ w_src[DW-1];
            nneg_reg <= n_src[DW-1];
            nzero_reg <= (n_src == '0);
            dsel_reg <= cmd.div_sel_y;
        end else if (dbusy_reg) begin
            dcnt_reg <= dcnt_reg + 6'd1;
            if (rem_sh >= dmag_reg && dmag_reg != '0) begin
                rem_reg <= rem_sh - dmag_reg;
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    logic ddone_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) ddone_reg <= 1'b0;
        else ddone_reg <= dbusy_reg && dcnt_reg == 6'(DW - 1) && !cmd.div_start;
    end
    assign stat.div_done = ddone_reg;

    logic signed [15:0] coord;
    logic fault_now;
    always_comb begin
        fault_now = (dmag_reg == '0);
        if (fault_now) begin
            coord = nzero_reg ? 16'sd0 : (nneg_reg ? -16'sd32768 : 16'sd32767);
        end else if (!dneg_reg) begin
            coord = (quo_reg > DW'(32767)) ? 16'sd32767 : 16'(quo_reg);
        end else begin
            coord = (quo_reg > DW'(32768)) ? -16'sd32768 : 16'(-quo_reg);
        end
    end

    // store the finished quotient by the numerator it was started on
    logic signed [15:0] px_reg, py_reg;
    logic fault_reg;
    always_ff @(posedge aclk) begin
        if (cmd.div_take) begin
            if (dsel_reg) py_reg <= coord;
            else px_reg <= coord;
            fault_reg <= dsel_reg ? (fault_reg | fault_now) : fault_now;
        end
    end

    // box scan: read one entry per cycle into registers and compare the registered entry
    logic [CW-1:0] sidx_reg;
    logic [2:0]    cls_reg;
    logic          rdv_reg;
    logic signed [15:0] rd_left_reg, rd_top_reg;
    logic [14:0]   rd_width_reg, rd_height_reg;
    logic [2:0]    rd_class_reg;
    logic          hit;
    logic [IW-1:0] si;
    logic signed [16:0] xr, yr;
    assign si = sidx_reg[IW-1:0];
    assign xr = 17'(rd_left_reg) + 17'(signed'({1'b0, rd_width_reg}));
    assign yr = 17'(rd_top_reg) + 17'(signed'({1'b0, rd_height_reg}));
    assign hit = rdv_reg && px_reg >= rd_left_reg && 17'(px_reg) < xr
        && py_reg >= rd_top_reg && 17'(py_reg) < yr && rd_class_reg != NO_CLASS;

    always_ff @(posedge aclk) begin
        if (cmd.scan_step) begin
            rd_left_reg   <= st_left[si];
            rd_top_reg    <= st_top[si];
            rd_width_reg  <= st_width[si];
            rd_height_reg <= st_height[si];
            rd_class_reg  <= st_class[si];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            sidx_reg <= '0;
            cls_reg <= NO_CLASS;
            rdv_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            rdv_reg <= (sidx_reg < count_reg);
            if (sidx_reg < count_reg) sidx_reg <= sidx_reg + 1'b1;
            if (hit) cls_reg <= rd_class_reg;
        end
    end
    // the last entry is compared at the same edge that ends the scan
    assign stat.scan_done = cmd.scan_step && sidx_reg >= count_reg;

    assign out_item.image_x = px_reg;
    assign out_item.image_y = py_reg;
    assign out_item.class_id = cls_reg;
    assign out_item.div_fault = fault_reg;

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_BOXES))
        else $error("box count overflow");
    a_cls_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step && !cmd.scan_start |-> cls_reg <= NO_CLASS)
        else $error("class out of range");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        ddone_reg |=> !ddone_reg)
        else $error("divider done held");
`endif
endmodule
`default_nettype wire

@@ sv/homography_point_box_classifier.sv @@
// Top level of the homography point box classifier: ports, controller and
// datapath. Depends on hpbc_pkg, hpbc_ctrl and hpbc_dpath.
`timescale 1ns / 1ps
`default_nettype none
// Op 0 clears the box list and op 1 appends a box; each gives no item. Op 2
// maps a bird's-eye point through the inverse homography (Q16.16, last
// entry one) and returns one item: the image point, divided by W truncating
// toward zero and saturated to 16 bits, the class of the last containing box
// with class 0 to 5 (else 6), and a fault flag for a zero W. An op 2 item
// passes through an accept, six products on the single 32x16 multiplier, a
// sum, two 50-bit restoring divisions at one quotient bit per cycle, a scan
// at one box per cycle and a result held until taken. One item is in work
// at a time. Writes at index above 7 are taken and dropped.
module homography_point_box_classifier #(
    parameter int MAX_BOXES = hpbc_pkg::MAX_BOXES_DEF
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire [3:0]            cfg_index,
    input  wire [31:0]           cfg_data,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  hpbc_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output hpbc_pkg::out_item_t  m_data
);
    import hpbc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // always take writes; drop those beyond the register list
    assign cfg_ready = 1'b1;

    hpbc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .in_op(s_data.op),
        .stat(stat), .cmd(cmd),
        .m_valid(m_valid), .m_ready(m_ready)
    );

    hpbc_dpath #(.MAX_BOXES(MAX_BOXES)) u_dpath (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid && !cfg_index[3]), .cfg_index(cfg_index[2:0]),
        .cfg_data(cfg_data),
        .in_item(s_data), .cmd(cmd), .stat(stat), .out_item(m_data)
    );

`ifndef NO_ASSERTIONS
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input valid withdrawn");
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result changed while stalled");
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("busy overlap");
`endif
endmodule
`default_nettype wire
